// File: hw/rtl/meter_needle_position_follower_macros.svh
// ----------------------------------------------------------------------------
// Meter needle position follower assertion macros
// Shared assertion forms used by the follower's RTL.
// ----------------------------------------------------------------------------
`ifndef METER_NEEDLE_POSITION_FOLLOWER_MACROS_SVH
`define METER_NEEDLE_POSITION_FOLLOWER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MNPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("follower check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define MNPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("follower check failed");

`endif

// File: hw/rtl/mnpf_pkg.sv
// ----------------------------------------------------------------------------
// Meter needle position follower package
// Constants, register indexes, direction codes and sequencer states.
// ----------------------------------------------------------------------------
package mnpf_pkg;

	localparam int WINDOW_LEN_DEF   = 100;
	localparam int SAMPLE_LIMIT_MV  = 550;
	localparam int ROUND_ZERO_STEPS = 2;
	localparam int TARGET_MAX       = 4095;

	localparam int CFG_W  = 12;
	localparam int IDX_W  = 3;
	localparam int SMP_W  = 10;
	localparam int POS_W  = 12;
	localparam int MUL_BW = 12;

	localparam logic [IDX_W-1:0] REG_INPUT_RANGE = 3'd0;
	localparam logic [IDX_W-1:0] REG_RANGE_STEPS = 3'd1;
	localparam logic [IDX_W-1:0] REG_METER_SPAN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SENSOR_SPAN = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_STEPS   = 3'd4;
	localparam logic [IDX_W-1:0] REG_FAST_THR    = 3'd5;
	localparam logic [IDX_W-1:0] REG_HYSTERESIS  = 3'd6;
	localparam logic [IDX_W-1:0] REG_FULL_TURN   = 3'd7;

	localparam logic [1:0] DIR_STILL = 2'd0;
	localparam logic [1:0] DIR_CW    = 2'd1;
	localparam logic [1:0] DIR_CCW   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic win_upd;
		logic num_ld;
		logic den_ld;
		logic div_start;
		logic fin;
	} ctrl_t;

endpackage

// File: hw/rtl/mnpf_divider.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module mnpf_divider #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// File: hw/rtl/meter_needle_position_follower.sv
// ----------------------------------------------------------------------------
// Meter needle position follower
// Moving-average filter, step scaling and hysteresis for a stepper meter.
// ----------------------------------------------------------------------------
// The result of a park word is loaded in the finish state as soon as the
// output register is free. A sample word goes through the window update,
// four passes through the shared multiplier, a start step and the serial
// divider, which yields one quotient bit per cycle over its NUM_W bits,
// with NUM_W = clog2(550 * WINDOW_LEN + 1) + 21; its result is then loaded
// in the finish state in the same way. The next word can be accepted in the
// cycle after the result is loaded. One word is in work at a time; a
// finished result waits in the output register while the next word is
// accepted. Window entries start as zero through per-entry valid bits, so
// there is no clearing pass after reset.
module meter_needle_position_follower #(
	parameter int WINDOW_LEN = mnpf_pkg::WINDOW_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [mnpf_pkg::IDX_W-1:0] cfg_index,
	input  logic [mnpf_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [11:0]                sample_mv,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 direction,
	output logic [11:0]                step_count,
	output logic [11:0]                target_steps,
	output logic                       within_range
);

	import mnpf_pkg::*;

	localparam int SLOT_W  = $clog2(WINDOW_LEN);
	localparam int SUM_W   = $clog2(SAMPLE_LIMIT_MV * WINDOW_LEN + 1);
	localparam int THR_W   = $clog2(1023 * WINDOW_LEN + 1);
	localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int NUM1_W  = SUM_W + 12;
	localparam int NUM_W   = NUM1_W + 9;
	localparam int DEN_W   = $clog2(WINDOW_LEN + 1) + 21;
	localparam int PROD_W  = NUM1_W + MUL_BW;

	// Configuration registers.
	logic [11:0] in_range_q;
	logic [11:0] range_steps_q;
	logic [8:0]  meter_span_q;
	logic [8:0]  sensor_span_q;
	logic [11:0] max_steps_q;
	logic [9:0]  fast_thr_q;
	logic [7:0]  hyst_q;
	logic        full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q    <= 12'd460;
			range_steps_q <= 12'd350;
			meter_span_q  <= 9'd250;
			sensor_span_q <= 9'd316;
			max_steps_q   <= 12'd800;
			fast_thr_q    <= 10'd10;
			hyst_q        <= 8'd1;
			full_q        <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INPUT_RANGE: in_range_q    <= cfg_data[11:0];
				REG_RANGE_STEPS: range_steps_q <= cfg_data[11:0];
				REG_METER_SPAN:  meter_span_q  <= cfg_data[8:0];
				REG_SENSOR_SPAN: sensor_span_q <= cfg_data[8:0];
				REG_MAX_STEPS:   max_steps_q   <= cfg_data[11:0];
				REG_FAST_THR:    fast_thr_q    <= cfg_data[9:0];
				REG_HYSTERESIS:  hyst_q        <= cfg_data[7:0];
				REG_FULL_TURN:   full_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	state_t state_q, state_d;
	ctrl_t  ctl;
	logic   park_q;
	logic   div_done;
	logic   fin_load;

	assign fin_load = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = mode ? ST_FIN : ST_UPD;
				end
			end
			ST_UPD:      state_d = ST_MUL1;
			ST_MUL1:     state_d = ST_MUL2;
			ST_MUL2:     state_d = ST_MUL3;
			ST_MUL3:     state_d = ST_MUL4;
			ST_MUL4:     state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:   ctl.in_ready  = 1'b1;
			ST_UPD:    ctl.win_upd   = 1'b1;
			ST_MUL1:   ctl.num_ld    = 1'b1;
			ST_MUL2:   ctl.num_ld    = 1'b1;
			ST_MUL3:   ctl.den_ld    = 1'b1;
			ST_MUL4:   ctl.den_ld    = 1'b1;
			ST_DIV_GO: ctl.div_start = 1'b1;
			ST_FIN:    ctl.fin       = fin_load;
			default:   ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = ctl.in_ready;

	// Window store, valid bits and running sum.
	logic [SMP_W-1:0]      mem [WINDOW_LEN];
	logic [SMP_W-1:0]      rd_q;
	logic [WINDOW_LEN-1:0] valid_q;
	logic [SMP_W-1:0]      fill_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SMP_W-1:0]      s_q;
	logic [SMP_W-1:0]      old_smp;
	logic [SUM_W-1:0]      scaled;
	logic [SUM_W-1:0]      dev;
	logic [THR_W-1:0]      thr;
	logic                  refill;
	logic                  win_wr;

	assign old_smp = valid_q[slot_q] ? rd_q : fill_q;
	assign scaled  = SUM_W'(s_q) * SUM_W'(WINDOW_LEN);
	assign dev     = (sum_q > scaled) ? (sum_q - scaled) : (scaled - sum_q);
	assign thr     = THR_W'(fast_thr_q) * THR_W'(WINDOW_LEN);
	assign refill  = CMP_W'(dev) >= CMP_W'(thr);
	assign win_wr  = ctl.win_upd && !refill;

	always_ff @(posedge clk) begin
		if (win_wr) begin
			mem[slot_q] <= s_q;
		end
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (in_valid && ctl.in_ready) begin
			park_q <= mode;
			s_q    <= (sample_mv > 12'(SAMPLE_LIMIT_MV)) ? '0 : sample_mv[SMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
		end else if (ctl.win_upd) begin
			if (refill) begin
				valid_q <= '0;
				fill_q  <= s_q;
				sum_q   <= scaled;
			end else begin
				valid_q[slot_q] <= 1'b1;
				sum_q           <= sum_q - SUM_W'(old_smp) + SUM_W'(s_q);
				slot_q          <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 :
					slot_q + SLOT_W'(1);
			end
		end
	end

	// Shared multiplier builds numerator and denominator.
	logic [11:0]       in_range_nz;
	logic [8:0]        sensor_nz;
	logic [NUM1_W-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;

	assign in_range_nz = (in_range_q == '0) ? 12'd1 : in_range_q;
	assign sensor_nz   = (sensor_span_q == '0) ? 9'd1 : sensor_span_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				mul_a = NUM1_W'(sum_q);
				mul_b = full_q ? max_steps_q : range_steps_q;
			end
			ST_MUL2: begin
				mul_a = num_q[NUM1_W-1:0];
				mul_b = full_q ? MUL_BW'(1) : MUL_BW'(meter_span_q);
			end
			ST_MUL3: begin
				mul_a = NUM1_W'(in_range_nz);
				mul_b = MUL_BW'(WINDOW_LEN);
			end
			ST_MUL4: begin
				mul_a = NUM1_W'(den_q);
				mul_b = full_q ? MUL_BW'(1) : MUL_BW'(sensor_nz);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (ctl.num_ld) begin
			num_q <= prod[NUM_W-1:0];
		end
		if (ctl.den_ld) begin
			den_q <= prod[DEN_W-1:0];
		end
	end

	logic [NUM_W-1:0] quo;
	logic [DEN_W-1:0] rem;

	mnpf_divider #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.div_start),
		.num   (num_q),
		.den   (den_q),
		.done  (div_done),
		.quo   (quo),
		.rem   (rem)
	);

	// Target, hysteresis and result register.
	logic [NUM_W-1:0] max_ext;
	logic             q_over;
	logic             ft_big;
	logic             ft_small;
	logic [11:0]      tgt;
	logic             tgt_within;
	logic [11:0]      pos_q;
	logic [11:0]      up_diff;
	logic [11:0]      dn_diff;
	logic             go_up;
	logic             go_dn;
	logic             out_valid_q;
	logic [1:0]       dir_q;
	logic [11:0]      cnt_q;
	logic [11:0]      tgt_q;
	logic             within_q;

	assign max_ext  = NUM_W'(max_steps_q);
	assign q_over   = quo > max_ext;
	assign ft_big   = q_over || (quo == max_ext && rem != '0);
	assign ft_small = (quo < NUM_W'(ROUND_ZERO_STEPS)) ||
		(quo == NUM_W'(ROUND_ZERO_STEPS) && rem == '0);

	always_comb begin
		if (full_q) begin
			tgt_within = 1'b1;
			if (ft_big) begin
				tgt = max_steps_q;
			end else if (ft_small) begin
				tgt = '0;
			end else begin
				tgt = quo[11:0];
			end
		end else begin
			tgt_within = !q_over;
			tgt = (quo > NUM_W'(TARGET_MAX)) ? 12'(TARGET_MAX) : quo[11:0];
		end
	end

	assign up_diff = tgt - pos_q;
	assign dn_diff = pos_q - tgt;
	assign go_up   = (tgt > pos_q) && (up_diff >= 12'(hyst_q));
	assign go_dn   = (tgt < pos_q) && (dn_diff >= 12'(hyst_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (ctl.fin) begin
				out_valid_q <= 1'b1;
				if (park_q) begin
					pos_q <= '0;
				end else if (go_up || go_dn) begin
					pos_q <= tgt;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			if (park_q) begin
				dir_q    <= (pos_q != '0) ? DIR_CCW : DIR_STILL;
				cnt_q    <= pos_q;
				tgt_q    <= '0;
				within_q <= 1'b1;
			end else begin
				dir_q    <= go_up ? DIR_CW : (go_dn ? DIR_CCW : DIR_STILL);
				cnt_q    <= go_up ? up_diff : (go_dn ? dn_diff : '0);
				tgt_q    <= tgt;
				within_q <= tgt_within;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign direction    = dir_q;
	assign step_count   = cnt_q;
	assign target_steps = tgt_q;
	assign within_range = within_q;

	`include "meter_needle_position_follower_macros.svh"

	`MNPF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`MNPF_ASSERT_SAME(a_sum_bound, clk, arst_n, 1'b1, sum_q <= SUM_W'(SAMPLE_LIMIT_MV * WINDOW_LEN))
	`MNPF_ASSERT_SAME(a_still_no_steps, clk, arst_n, out_valid && direction == DIR_STILL, step_count == '0)
	`MNPF_ASSERT_SAME(a_dir_code, clk, arst_n, out_valid, direction == DIR_STILL || direction == DIR_CW || direction == DIR_CCW)

endmodule
